// ===== src/sitd_pkg.sv =====
// Shared types and constants for the signed integer to decimal text block.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package sitd_pkg;

    localparam int VALUE_W = 32;
    localparam int MAG_W   = 31;
    localparam int CHAR_W  = 6;

    // Number of decimal positions rendered; higher digits are dropped.
    localparam int MAX_DIGITS  = 10;
    localparam int KEPT_DIGITS = (MAX_DIGITS < 1) ? 1 : ((MAX_DIGITS > 10) ? 10 : MAX_DIGITS);

    // A 31-bit magnitude never has more than ten decimal digits.
    localparam int POS_W   = 4;
    localparam int TOP_POS = 9;
    localparam int STEP_W  = 34;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;

    localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic   empty;
        t_entry entry;
    } t_head;

    // Power of ten for a digit position, from a constant table.
    function automatic logic [STEP_W-1:0] pow10(input logic [POS_W-1:0] pos);
        logic [STEP_W-1:0] v;
        unique case (pos)
            4'd0:    v = 34'd1;
            4'd1:    v = 34'd10;
            4'd2:    v = 34'd100;
            4'd3:    v = 34'd1000;
            4'd4:    v = 34'd10000;
            4'd5:    v = 34'd100000;
            4'd6:    v = 34'd1000000;
            4'd7:    v = 34'd10000000;
            4'd8:    v = 34'd100000000;
            4'd9:    v = 34'd1000000000;
            default: v = 34'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== src/sitd_if.sv =====
// Valid/ready channel interfaces for the number input and the character output.
// Depends on sitd_pkg for payload widths.
`default_nettype none

interface sitd_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [sitd_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sitd_out_if;
    logic                        valid;
    logic                        ready;
    logic [sitd_pkg::CHAR_W-1:0] character;
    logic                        last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// ===== src/sitd_front.sv =====
// Front end: accepts numbers, drops the most negative value, splits sign and magnitude.
// Depends on sitd_pkg and sitd_in_if.
`default_nettype none

module sitd_front (
    sitd_in_if.sink          i_in,
    input  wire logic        i_full,
    output sitd_pkg::t_push  o_push
);

    logic [sitd_pkg::VALUE_W-1:0] w_raw;
    logic [sitd_pkg::VALUE_W-1:0] w_abs;

    assign i_in.ready = !i_full;
    assign w_raw      = i_in.value;
    assign w_abs      = w_raw[sitd_pkg::VALUE_W-1] ? (~w_raw + 32'd1) : w_raw;

    // The most negative value renders as no text at all, so it never enters the queue.
    always_comb begin
        o_push.valid     = i_in.valid && !i_full && (w_raw != sitd_pkg::VALUE_MIN);
        o_push.entry.neg = w_raw[sitd_pkg::VALUE_W-1];
        o_push.entry.mag = w_abs[sitd_pkg::MAG_W-1:0];
    end

endmodule

`default_nettype wire

// ===== src/sitd_queue.sv =====
// Short register queue between the front end and the digit engine.
// Depends on sitd_pkg.
`default_nettype none

module sitd_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire sitd_pkg::t_push  i_push,
    input  wire logic             i_pop,
    output logic                  o_full,
    output sitd_pkg::t_head       o_head
);

    localparam int PTR_W = (sitd_pkg::QUEUE_DEPTH > 1) ? $clog2(sitd_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(sitd_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(sitd_pkg::QUEUE_DEPTH - 1);

    sitd_pkg::t_entry r_mem [sitd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_pop;

    assign o_full       = (r_count == CNT_W'(sitd_pkg::QUEUE_DEPTH));
    assign o_head.empty = (r_count == '0);
    assign o_head.entry = r_mem[r_rd_ptr];
    assign w_pop        = i_pop && !o_head.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push.valid && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !i_push.valid) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

endmodule

`default_nettype wire

// ===== src/sitd_back.sv =====
// Digit engine: walks the decimal positions from the top, one per cycle unless the
// output stalls; drives the character output. Depends on sitd_pkg and sitd_out_if.
`default_nettype none

module sitd_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire sitd_pkg::t_head  i_head,
    output logic                  o_pop,
    sitd_out_if.source            o_out
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SIGN  = 3'b010,
        S_DIGIT = 3'b100
    } t_state;

    t_state                          r_state, n_state;
    logic [sitd_pkg::MAG_W-1:0]      r_rem, n_rem;
    logic [sitd_pkg::POS_W-1:0]      r_pos, n_pos;
    logic                            r_started, n_started;
    logic                            r_out_valid, n_out_valid;
    logic [sitd_pkg::CHAR_W-1:0]     r_out_char, n_out_char;
    logic                            r_out_last, n_out_last;

    logic [sitd_pkg::STEP_W-1:0]     w_pow;
    logic [sitd_pkg::STEP_W-1:0]     w_thresh [10];
    logic [3:0]                      w_digit;
    logic                            w_emit;
    logic                            w_can_load;

    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_out_char;
    assign o_out.last      = r_out_last;
    assign w_can_load      = !r_out_valid || o_out.ready;
    assign w_pow           = sitd_pkg::pow10(r_pos);

    // The digit is the largest multiple of the position weight that fits in the remainder.
    always_comb begin
        w_digit = 4'd0;
        for (int k = 0; k < 10; k++) begin
            w_thresh[k] = w_pow * sitd_pkg::STEP_W'(k);
        end
        for (int k = 1; k < 10; k++) begin
            if ({3'b000, r_rem} >= w_thresh[k]) begin
                w_digit = 4'(k);
            end
        end
    end

    // Positions above the kept range are still subtracted away but never shown.
    assign w_emit = (r_pos < sitd_pkg::POS_W'(sitd_pkg::KEPT_DIGITS))
                    && (r_started || (w_digit != 4'd0) || (r_pos == '0));

    always_comb begin
        n_state     = r_state;
        n_rem       = r_rem;
        n_pos       = r_pos;
        n_started   = r_started;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (!i_head.empty) begin
                    o_pop     = 1'b1;
                    n_rem     = i_head.entry.mag;
                    n_pos     = sitd_pkg::POS_W'(sitd_pkg::TOP_POS);
                    n_started = 1'b0;
                    n_state   = i_head.entry.neg ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN: begin
                if (w_can_load) begin
                    n_out_valid = 1'b1;
                    n_out_char  = sitd_pkg::CH_MINUS;
                    n_out_last  = 1'b0;
                    n_state     = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (!w_emit || w_can_load) begin
                    n_rem     = r_rem - w_thresh[w_digit][sitd_pkg::MAG_W-1:0];
                    n_pos     = r_pos - sitd_pkg::POS_W'(1);
                    n_started = r_started || w_emit;
                    if (w_emit) begin
                        n_out_valid = 1'b1;
                        n_out_char  = sitd_pkg::CH_ZERO + sitd_pkg::CHAR_W'(w_digit);
                        n_out_last  = (r_pos == '0);
                    end
                    if (r_pos == '0) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_pos      <= n_pos;
        r_started  <= n_started;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

endmodule

`default_nettype wire

// ===== src/signed_int_to_decimal_ascii.sv =====
// Top level: signed 32-bit integer to decimal ASCII characters.
// Depends on sitd_pkg, sitd_if, sitd_front, sitd_queue and sitd_back.
//
// Usage:
// i_in carries one signed 32-bit number per item. o_out carries one ASCII
// character per item, most significant first, with last set on the final
// character of each number. Negative numbers start with a minus sign, leading
// zeros are suppressed, zero gives a single '0', and the most negative value
// gives no characters.
// Any other number is written into a two-entry queue when it is accepted; the
// digit engine pops it from the queue when idle, loads the sign first if there
// is one and then walks the ten decimal positions, one per cycle unless the
// output stalls. The queue accepts new numbers while the engine is still working
// on the previous one, so the digit engine sets the sustained rate.
// The output register holds a character until it is taken; while the receiver
// stalls, the engine waits and the queue keeps accepting until it is full.
// Reset empties the queue, idles the engine and drops any pending character.
`default_nettype none

module signed_int_to_decimal_ascii (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    sitd_in_if.sink      i_in,
    sitd_out_if.source   o_out
);

    sitd_pkg::t_push w_push;
    sitd_pkg::t_head w_head;
    logic            w_full;
    logic            w_pop;

    sitd_front u_front (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push)
    );

    sitd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    sitd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ===== src/sitd_checker.sv =====
// Port-level checker for the decimal text block, bound to the top level.
// Depends on sitd_pkg.
`default_nettype none

module sitd_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_ready,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [sitd_pkg::CHAR_W-1:0] i_out_character,
    input wire logic                        i_out_last
);

    // A stalled character stays put until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_character)
                                        && $stable(i_out_last))
        else $error("output character changed while stalled");

    // Only the minus sign and the ten digits are ever shown.
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_character == sitd_pkg::CH_MINUS)
                        || ((i_out_character >= sitd_pkg::CH_ZERO)
                            && (i_out_character <= sitd_pkg::CH_ZERO + 6'd9)))
        else $error("output character outside the decimal set");

    // A number never ends on its sign.
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_character == sitd_pkg::CH_MINUS) |-> !i_out_last)
        else $error("minus sign marked as last character");

    // Reset leaves no pending character and a queue that is not full.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("block not cleared by reset");

endmodule

bind signed_int_to_decimal_ascii sitd_checker u_sitd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_character (o_out.character),
    .i_out_last      (o_out.last)
);

`default_nettype wire
